FILE: sv/mpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_pkg
// Types and codes shared by the priority queue, its cells and its channels.
// ----------------------------------------------------------------------------
package mpq_pkg;

	localparam int KEY_W    = 16;
	localparam int TAG_W    = 16;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 4;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_e;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	// Broadcast to every cell in the chain.
	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t new_entry;
	} cell_ctrl_t;

endpackage
`default_nettype wire

FILE: sv/mpq_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_req_if
// Command channel of the priority queue: push or pop, with key and tag.
// ----------------------------------------------------------------------------
interface mpq_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [15:0] key;
	logic [15:0] tag;

	modport source (output valid, output command, output key, output tag, input ready);
	modport sink (input valid, input command, input key, input tag, output ready);
endinterface
`default_nettype wire

FILE: sv/mpq_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_rsp_if
// Result channel of the priority queue: status, removed entry and fill level.
// ----------------------------------------------------------------------------
interface mpq_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] removed_key;
	logic [15:0] removed_tag;
	logic [3:0]  occupancy;
	logic        is_empty;
	logic        is_full;

	modport source (output valid, output status, output removed_key, output removed_tag,
		output occupancy, output is_empty, output is_full, input ready);
	modport sink (input valid, input status, input removed_key, input removed_tag,
		input occupancy, input is_empty, input is_full, output ready);
endinterface
`default_nettype wire

FILE: sv/mpq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted chain. Holds an entry; on a push it either keeps it,
// takes the new entry or takes its left neighbour's; on a pop it takes its
// right neighbour's.
// ----------------------------------------------------------------------------
module mpq_cell #(
	parameter int INDEX = 0,
	parameter int CW    = 4
) (
	input  wire                      clk,
	input  wire mpq_pkg::cell_ctrl_t ctrl,
	input  wire  [CW-1:0]            count,
	input  wire mpq_pkg::entry_t     left_entry,
	input  wire                      left_ins,
	input  wire mpq_pkg::entry_t     right_entry,
	output mpq_pkg::entry_t          entry,
	output logic                     ins
);
	import mpq_pkg::*;

	localparam logic [CW-1:0] INDEX_C = CW'(INDEX);

	entry_t entry_q;

	// Entries are held in descending key order, so the insert flag is low up
	// to the new entry's place and high from there on. Equal keys stay ahead
	// of the newcomer, which keeps earlier pushes first among ties.
	always_comb begin
		ins = (INDEX_C >= count) || (entry_q.key < ctrl.new_entry.key);
	end

	always_ff @(posedge clk) begin
		if (ctrl.push && ins) begin
			entry_q <= left_ins ? left_entry : ctrl.new_entry;
		end else if (ctrl.pop) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire

FILE: sv/max_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// max_priority_queue
// Bounded max-priority queue built as a chain of sorted cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command word: push (key, tag) or pop. rsp returns one word
//   per command: status, the removed entry on a successful pop (zero
//   otherwise), and the occupancy with empty and full flags after the command.
//   Each command is handled in the cycle it is accepted and its result word
//   sits in the output register from the next cycle: throughput one word per
//   cycle for any mix of pushes and pops unless the receiver stalls. The
//   cells keep the entries sorted by key, largest at the head, so a push
//   is one parallel compare along the chain and a pop takes the head.
//   Among equal keys the earliest pushed entry leaves first.
//   A push into a full queue or a pop from an empty one leaves the contents
//   alone and reports a reject status.
//   Reset empties the queue and drops any pending result word. When the
//   receiver stalls, the result word is held and req.ready stays low until
//   it is taken; a new word is accepted in the cycle the old one leaves.
// ----------------------------------------------------------------------------
module max_priority_queue #(
	parameter int CAPACITY = 8
) (
	input  wire   clk,
	input  wire   arst_n,
	mpq_req_if.sink   req,
	mpq_rsp_if.source rsp
);
	import mpq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic              accept;
	logic              is_pop;
	logic              full;
	logic              empty;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_d;
	cell_ctrl_t        ctrl;
	entry_t            cell_entry [CAPACITY];
	logic              cell_ins   [CAPACITY];

	logic              rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [KEY_W-1:0]  removed_key_q;
	logic [TAG_W-1:0]  removed_tag_q;
	logic [CW-1:0]     occ_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign is_pop    = (req.command == CMD_POP);
	assign full      = (count_q == CAP_C);
	assign empty     = (count_q == '0);

	always_comb begin
		ctrl.push              = accept && !is_pop && !full;
		ctrl.pop               = accept && is_pop && !empty;
		ctrl.new_entry.key     = req.key;
		ctrl.new_entry.tag     = req.tag;
	end

	always_comb begin
		count_d = count_q;
		if (ctrl.push) begin
			count_d = count_q + CW'(1);
		end else if (ctrl.pop) begin
			count_d = count_q - CW'(1);
		end
	end

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			entry_t left_entry;
			logic   left_ins;
			entry_t right_entry;

			if (g == 0) begin : g_head
				assign left_entry = '0;
				assign left_ins   = 1'b0;
			end else begin : g_body
				assign left_entry = cell_entry[g-1];
				assign left_ins   = cell_ins[g-1];
			end

			if (g == CAPACITY - 1) begin : g_tail
				assign right_entry = '0;
			end else begin : g_inner
				assign right_entry = cell_entry[g+1];
			end

			mpq_cell #(
				.INDEX (g),
				.CW    (CW)
			) u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.count       (count_q),
				.left_entry  (left_entry),
				.left_ins    (left_ins),
				.right_entry (right_entry),
				.entry       (cell_entry[g]),
				.ins         (cell_ins[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			occ_q <= count_d;
			if (is_pop) begin
				status_q      <= empty ? ST_EMPTY : ST_DONE;
				removed_key_q <= empty ? '0 : cell_entry[0].key;
				removed_tag_q <= empty ? '0 : cell_entry[0].tag;
			end else begin
				status_q      <= full ? ST_FULL : ST_DONE;
				removed_key_q <= '0;
				removed_tag_q <= '0;
			end
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.removed_key = removed_key_q;
	assign rsp.removed_tag = removed_tag_q;
	assign rsp.occupancy   = OCC_W'(occ_q);
	assign rsp.is_empty    = (occ_q == '0);
	assign rsp.is_full     = (occ_q == CAP_C);

endmodule
`default_nettype wire
